[hdl/skt_pkg.sv]
// Shared types and constants for the sorted key table lookup block.
package skt_pkg;

  localparam int unsigned KEY_W    = 32;
  localparam int unsigned HANDLE_W = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned APB_AW   = 2;
  localparam int unsigned APB_DW   = 32;

  // Register byte address of the reserved key.
  localparam logic [APB_AW-1:0] REG_RESERVED_KEY = 2'd0;

  // Reset value of the reserved key.
  localparam logic [KEY_W-1:0] RESERVED_KEY_RST = 32'd2;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_SORT   = 2'd2,
    ACT_LOOKUP = 2'd3
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_UNSORTED = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SORT_RD,
    S_SORT_LD,
    S_SORT_CMP,
    S_SORT_PLACE,
    S_SRCH,
    S_SRCH_CMP,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

  typedef struct packed {
    logic                found;
    logic                reserved_hit;
    logic [HANDLE_W-1:0] match_handle;
    status_e             status;
  } result_t;

endpackage

[hdl/skt_if.sv]
// Valid/ready channel interfaces for input items and result items.
interface skt_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    action;
  logic [skt_pkg::KEY_W-1:0]     key;
  logic [skt_pkg::HANDLE_W-1:0]  handle;

  modport source (output valid, action, key, handle, input ready);
  modport sink   (input valid, action, key, handle, output ready);
endinterface

interface skt_out_if;
  logic                          valid;
  logic                          ready;
  logic                          found;
  logic                          reserved_hit;
  logic [skt_pkg::HANDLE_W-1:0]  match_handle;
  logic [skt_pkg::STATUS_W-1:0]  status;

  modport source (output valid, found, reserved_hit, match_handle, status, input ready);
  modport sink   (input valid, found, reserved_hit, match_handle, status, output ready);
endinterface

[hdl/skt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module skt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

[hdl/skt_cfg.sv]
// APB register file holding the reserved key.
module skt_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [skt_pkg::APB_AW-1:0]   paddr,
  input  logic [skt_pkg::APB_DW-1:0]   pwdata,
  output logic [skt_pkg::APB_DW-1:0]   prdata,
  output logic                         pready,
  output logic [skt_pkg::KEY_W-1:0]    reserved_key_o
);

  logic [skt_pkg::KEY_W-1:0] rkey_q, rkey_d;
  logic                      wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr == skt_pkg::REG_RESERVED_KEY);

  // Register write decode.
  always_comb begin
    rkey_d = rkey_q;
    if (wr_en) begin
      rkey_d = pwdata[skt_pkg::KEY_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rkey_q <= skt_pkg::RESERVED_KEY_RST;
    end else begin
      rkey_q <= rkey_d;
    end
  end

  // Read mux.
  always_comb begin
    prdata = '0;
    unique case (paddr)
      skt_pkg::REG_RESERVED_KEY: prdata = rkey_q;
      default:                   prdata = '0;
    endcase
  end

  assign reserved_key_o = rkey_q;

endmodule

[hdl/skt_ctrl.sv]
// Sequencer for clear, insert, insertion sort and binary search over the table RAM.
module skt_ctrl #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  skt_in_if.sink                              in_i,
  skt_out_if.source                           out_o,
  input  logic [skt_pkg::KEY_W-1:0]           reserved_key_i,
  output logic                                ram_we_o,
  output logic [$clog2(TABLE_DEPTH)-1:0]      ram_waddr_o,
  output skt_pkg::entry_t                     ram_wdata_o,
  output logic [$clog2(TABLE_DEPTH)-1:0]      ram_raddr_o,
  input  skt_pkg::entry_t                     ram_rdata_i
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  skt_pkg::state_e  state_q, state_d;
  logic [CW-1:0]    count_q, count_d;
  logic             sorted_q, sorted_d;
  logic [CW-1:0]    i_q, i_d;
  logic [AW-1:0]    j_q, j_d;
  logic [CW-1:0]    lo_q, lo_d;
  logic [CW-1:0]    hi1_q, hi1_d;
  logic [AW-1:0]    mid_q, mid_d;
  skt_pkg::entry_t  cur_q, cur_d;
  skt_pkg::result_t res_q, res_d;
  skt_pkg::result_t outr_q, outr_d;
  logic             ovalid_q, ovalid_d;

  logic             accept;
  logic             out_free;
  logic [CW:0]      msum;
  logic [AW-1:0]    mid_c;
  logic [CW-1:0]    i_inc;
  logic [CW-1:0]    i_dec;
  logic             key_gt;

  assign accept   = in_i.valid && in_i.ready;
  assign out_free = !ovalid_q || out_o.ready;
  assign msum     = {1'b0, lo_q} + {1'b0, hi1_q} - {{CW{1'b0}}, 1'b1};
  assign mid_c    = msum[AW:1];
  assign i_inc    = i_q + {{(CW-1){1'b0}}, 1'b1};
  assign i_dec    = i_q - {{(CW-1){1'b0}}, 1'b1};
  assign key_gt   = ram_rdata_i.key > cur_q.key;

  assign in_i.ready         = (state_q == skt_pkg::S_IDLE);
  assign out_o.valid        = ovalid_q;
  assign out_o.found        = outr_q.found;
  assign out_o.reserved_hit = outr_q.reserved_hit;
  assign out_o.match_handle = outr_q.match_handle;
  assign out_o.status       = outr_q.status;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      skt_pkg::S_IDLE: begin
        if (accept) begin
          unique case (skt_pkg::action_e'(in_i.action))
            skt_pkg::ACT_SORT: begin
              state_d = (count_q > {{(CW-1){1'b0}}, 1'b1}) ? skt_pkg::S_SORT_RD
                                                            : skt_pkg::S_RESP;
            end
            skt_pkg::ACT_LOOKUP: begin
              state_d = (in_i.key != reserved_key_i && sorted_q) ? skt_pkg::S_SRCH
                                                                   : skt_pkg::S_RESP;
            end
            default: state_d = skt_pkg::S_RESP;
          endcase
        end
      end
      skt_pkg::S_SORT_RD:  state_d = skt_pkg::S_SORT_LD;
      skt_pkg::S_SORT_LD:  state_d = skt_pkg::S_SORT_CMP;
      skt_pkg::S_SORT_CMP: begin
        if (key_gt) begin
          if (j_q == {{(AW-1){1'b0}}, 1'b1}) begin
            state_d = skt_pkg::S_SORT_PLACE;
          end
        end else begin
          state_d = (i_inc >= count_q) ? skt_pkg::S_RESP : skt_pkg::S_SORT_RD;
        end
      end
      skt_pkg::S_SORT_PLACE: begin
        state_d = (i_inc >= count_q) ? skt_pkg::S_RESP : skt_pkg::S_SORT_RD;
      end
      skt_pkg::S_SRCH: begin
        state_d = (lo_q < hi1_q) ? skt_pkg::S_SRCH_CMP : skt_pkg::S_RESP;
      end
      skt_pkg::S_SRCH_CMP: begin
        if (cur_q.key == ram_rdata_i.key) begin
          state_d = skt_pkg::S_RESP;
        end else begin
          state_d = skt_pkg::S_SRCH;
        end
      end
      skt_pkg::S_RESP: begin
        if (out_free) begin
          state_d = skt_pkg::S_IDLE;
        end
      end
      default: state_d = skt_pkg::S_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    count_d     = count_q;
    sorted_d    = sorted_q;
    i_d         = i_q;
    j_d         = j_q;
    lo_d        = lo_q;
    hi1_d       = hi1_q;
    mid_d       = mid_q;
    cur_d       = cur_q;
    res_d       = res_q;
    outr_d      = outr_q;
    ovalid_d    = ovalid_q && !out_o.ready;
    ram_we_o    = 1'b0;
    ram_waddr_o = j_q;
    ram_wdata_o = cur_q;
    ram_raddr_o = i_q[AW-1:0];

    unique case (state_q)
      skt_pkg::S_IDLE: begin
        if (accept) begin
          res_d     = '0;
          cur_d.key = in_i.key;
          unique case (skt_pkg::action_e'(in_i.action))
            skt_pkg::ACT_CLEAR: begin
              count_d  = '0;
              sorted_d = 1'b1;
            end
            skt_pkg::ACT_INSERT: begin
              if (count_q >= CW'(TABLE_DEPTH)) begin
                res_d.status = skt_pkg::ST_FULL;
              end else begin
                ram_we_o    = 1'b1;
                ram_waddr_o = count_q[AW-1:0];
                ram_wdata_o = '{key: in_i.key, handle: in_i.handle};
                count_d     = count_q + {{(CW-1){1'b0}}, 1'b1};
                sorted_d    = 1'b0;
              end
            end
            skt_pkg::ACT_SORT: begin
              i_d      = {{(CW-1){1'b0}}, 1'b1};
              sorted_d = 1'b1;
            end
            default: begin
              if (in_i.key == reserved_key_i) begin
                res_d.found        = 1'b1;
                res_d.reserved_hit = 1'b1;
              end else if (!sorted_q) begin
                res_d.status = skt_pkg::ST_UNSORTED;
              end else begin
                lo_d  = '0;
                hi1_d = count_q;
              end
            end
          endcase
        end
      end
      // Fetch the entry to be inserted into the sorted prefix.
      skt_pkg::S_SORT_RD: begin
        ram_raddr_o = i_q[AW-1:0];
      end
      skt_pkg::S_SORT_LD: begin
        cur_d       = ram_rdata_i;
        j_d         = i_q[AW-1:0];
        ram_raddr_o = i_dec[AW-1:0];
      end
      // Shift larger entries up one place, then drop the held entry in.
      skt_pkg::S_SORT_CMP: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = j_q;
        if (key_gt) begin
          ram_wdata_o = ram_rdata_i;
          j_d         = j_q - {{(AW-1){1'b0}}, 1'b1};
          ram_raddr_o = j_q - AW'(2);
        end else begin
          ram_wdata_o = cur_q;
          i_d         = i_inc;
        end
      end
      skt_pkg::S_SORT_PLACE: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = j_q;
        ram_wdata_o = cur_q;
        i_d         = i_inc;
      end
      // Issue one probe at the floor midpoint.
      skt_pkg::S_SRCH: begin
        ram_raddr_o = mid_c;
        mid_d       = mid_c;
      end
      skt_pkg::S_SRCH_CMP: begin
        if (cur_q.key < ram_rdata_i.key) begin
          hi1_d = CW'(mid_q);
        end else if (cur_q.key > ram_rdata_i.key) begin
          lo_d = CW'(mid_q) + {{(CW-1){1'b0}}, 1'b1};
        end else begin
          res_d.found        = 1'b1;
          res_d.match_handle = ram_rdata_i.handle;
        end
      end
      skt_pkg::S_RESP: begin
        if (out_free) begin
          outr_d   = res_q;
          ovalid_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= skt_pkg::S_IDLE;
      count_q  <= '0;
      sorted_q <= 1'b1;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      sorted_q <= sorted_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q    <= i_d;
    j_q    <= j_d;
    lo_q   <= lo_d;
    hi1_q  <= hi1_d;
    mid_q  <= mid_d;
    cur_q  <= cur_d;
    res_q  <= res_d;
    outr_q <= outr_d;
  end

endmodule

[hdl/sorted_key_table_lookup.sv]
// Clear, insert and reserved or unsorted lookups go straight to the result state.
// A lookup makes binary search probes via the RAM read port, log2(TABLE_DEPTH)+1 at most.
// A sort is an insertion sort: each entry is read and compared, and larger entries shift up.
// One item is worked on at a time; the next is taken once the result is queued.
// Reset clears the table count, marks it sorted and sets the reserved key to 2.
module sorted_key_table_lookup #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  skt_in_if.sink                     in_i,
  skt_out_if.source                  out_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [skt_pkg::APB_AW-1:0] paddr,
  input  logic [skt_pkg::APB_DW-1:0] pwdata,
  output logic [skt_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  logic [skt_pkg::KEY_W-1:0] reserved_key;
  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  logic [AW-1:0]             ram_raddr;
  skt_pkg::entry_t           ram_wdata;
  skt_pkg::entry_t           ram_rdata;

  // Configuration registers.
  skt_cfg u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .reserved_key_o (reserved_key)
  );

  // Sequencer.
  skt_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_i           (in_i),
    .out_o          (out_o),
    .reserved_key_i (reserved_key),
    .ram_we_o       (ram_we),
    .ram_waddr_o    (ram_waddr),
    .ram_wdata_o    (ram_wdata),
    .ram_raddr_o    (ram_raddr),
    .ram_rdata_i    (ram_rdata)
  );

  // Key and handle table.
  skt_ram #(
    .Width ($bits(skt_pkg::entry_t)),
    .Depth (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // One item at a time: the block is busy in the cycle after a transfer.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input accepted while previous item still in progress");

  // While idle, the table is only written by an accepted insert.
  a_idle_write_is_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && in_i.ready) |->
      (in_i.valid && in_i.action == skt_pkg::ACT_INSERT))
    else $error("table written while idle without an insert");

  // A new result only appears after the block has been busy.
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(!in_i.ready))
    else $error("result produced without an item in progress");

endmodule

[test/skt_checker.sv]
// Checker that predicts the table lookup results and compares them with the block's transfers.
`timescale 1ns / 1ps
module skt_checker
  import skt_pkg::*;
#(
  parameter int unsigned DEPTH = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  skt_in_if                   mon_in,
  skt_out_if                  mon_out,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  input  logic                pready,
  output int                  err_cnt_o,
  output int                  pending_o
);

  // Shadow copy of the table and of the reserved key register.
  logic [KEY_W-1:0]    tbl_keys    [DEPTH];
  logic [HANDLE_W-1:0] tbl_handles [DEPTH];
  int unsigned         tbl_count;
  bit                  tbl_sorted;
  logic [KEY_W-1:0]    resv_key;

  result_t expected_results[$];

  assign pending_o = expected_results.size();

  // Stable insertion sort of the shadow table.
  function automatic void sort_table();
    logic [KEY_W-1:0]    k;
    logic [HANDLE_W-1:0] h;
    int                  j;
    for (int i = 1; i < tbl_count; i++) begin
      k = tbl_keys[i];
      h = tbl_handles[i];
      j = i;
      while (j > 0 && tbl_keys[j-1] > k) begin
        tbl_keys[j]    = tbl_keys[j-1];
        tbl_handles[j] = tbl_handles[j-1];
        j--;
      end
      tbl_keys[j]    = k;
      tbl_handles[j] = h;
    end
  endfunction

  // Applies one item to the shadow table and returns the result it causes.
  function automatic result_t predict_result(action_e act, logic [KEY_W-1:0] k,
                                             logic [HANDLE_W-1:0] h);
    result_t r;
    int      lo;
    int      hi;
    int      mid;
    r = '{found: 1'b0, reserved_hit: 1'b0, match_handle: '0, status: ST_OK};
    case (act)
      ACT_CLEAR: begin
        tbl_count  = 0;
        tbl_sorted = 1'b1;
      end
      ACT_INSERT: begin
        if (tbl_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          tbl_keys[tbl_count]    = k;
          tbl_handles[tbl_count] = h;
          tbl_count++;
          tbl_sorted = 1'b0;
        end
      end
      ACT_SORT: begin
        sort_table();
        tbl_sorted = 1'b1;
      end
      default: begin
        if (k == resv_key) begin
          r.found        = 1'b1;
          r.reserved_hit = 1'b1;
        end else if (!tbl_sorted) begin
          r.status = ST_UNSORTED;
        end else begin
          // Binary search with inclusive bounds and a floor midpoint.
          lo = 0;
          hi = int'(tbl_count) - 1;
          while (lo <= hi) begin
            mid = (lo + hi) / 2;
            if (k < tbl_keys[mid]) begin
              hi = mid - 1;
            end else if (k > tbl_keys[mid]) begin
              lo = mid + 1;
            end else begin
              r.found        = 1'b1;
              r.match_handle = tbl_handles[mid];
              break;
            end
          end
        end
      end
    endcase
    return r;
  endfunction

  // Register writes, input transfers and result transfers, all sampled at the rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    result_t exp_r;
    if (!rst_ni) begin
      tbl_count  = 0;
      tbl_sorted = 1'b1;
      resv_key   = RESERVED_KEY_RST;
      expected_results.delete();
      err_cnt_o  = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == REG_RESERVED_KEY) begin
        resv_key = pwdata;
      end
      if (mon_out.valid && mon_out.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result transfer with nothing expected", $time);
          err_cnt_o++;
        end else begin
          exp_r = expected_results.pop_front();
          if (mon_out.found !== exp_r.found) begin
            $display("%0t: found expected %0b actual %0b", $time, exp_r.found, mon_out.found);
            err_cnt_o++;
          end
          if (mon_out.reserved_hit !== exp_r.reserved_hit) begin
            $display("%0t: reserved_hit expected %0b actual %0b", $time,
                     exp_r.reserved_hit, mon_out.reserved_hit);
            err_cnt_o++;
          end
          if (mon_out.match_handle !== exp_r.match_handle) begin
            $display("%0t: match_handle expected %h actual %h", $time,
                     exp_r.match_handle, mon_out.match_handle);
            err_cnt_o++;
          end
          if (mon_out.status !== exp_r.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_r.status, mon_out.status);
            err_cnt_o++;
          end
        end
      end
      if (mon_in.valid && mon_in.ready) begin
        expected_results.push_back(predict_result(action_e'(mon_in.action), mon_in.key,
                                                  mon_in.handle));
      end
    end
  end

endmodule

[test/tb_top.sv]
// Testbench top: clock, reset, stimulus, register writes and the verdict.
`timescale 1ns / 1ps
module tb_top;
  import skt_pkg::*;

  localparam int unsigned DEPTH      = 1024;
  localparam int unsigned ITEMS      = 1600;
  // Items left for the random phases after the directed and full-table items.
  localparam int unsigned RAND_ITEMS = ITEMS - DEPTH - 23;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  int                err_cnt;
  int                pending;
  bit                no_stall;
  logic [KEY_W-1:0]  cur_resv;
  int unsigned       sent_cnt;
  int unsigned       table_fill;
  logic [KEY_W-1:0]  loaded_keys[$];

  skt_in_if  in_if ();
  skt_out_if out_if ();

  sorted_key_table_lookup #(.TABLE_DEPTH(DEPTH)) u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if.sink),
    .out_o   (out_if.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  skt_checker #(.DEPTH(DEPTH)) u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .mon_in    (in_if),
    .mon_out   (out_if),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .pready    (pready),
    .err_cnt_o (err_cnt),
    .pending_o (pending)
  );

  always #10 clk_i = ~clk_i;

  // Mostly short gaps, a few long ones, none during stall-free stretches.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_stall || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // Result side back-pressure.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_if.ready = (pick_gap() == 0);
    end
  end

  // Drives one item and returns after its transfer.
  task automatic send_item(action_e act, logic [KEY_W-1:0] k, logic [HANDLE_W-1:0] h);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid  = 1'b1;
    in_if.action = act;
    in_if.key    = k;
    in_if.handle = h;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
    in_if.valid = 1'b0;
    sent_cnt++;
    if (act == ACT_CLEAR) begin
      table_fill = 0;
      loaded_keys.delete();
    end else if (act == ACT_INSERT) begin
      table_fill++;
      loaded_keys.push_back(k);
    end
  endtask

  // Waits until every result is in and the block has settled, then writes the register.
  task automatic write_resv(logic [KEY_W-1:0] value);
    while (pending != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    psel    = 1'b1;
    pwrite  = 1'b1;
    paddr   = REG_RESERVED_KEY;
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    cur_resv = value;
  endtask

  // Random well-formed load, sort and lookup sequences with some noise mixed in.
  task automatic random_phase(int unsigned n_items);
    int unsigned      stop_at;
    int unsigned      m;
    logic [KEY_W-1:0] k;
    stop_at = sent_cnt + n_items;
    while (sent_cnt < stop_at) begin
      no_stall = ($urandom_range(0, 9) == 0);
      if (table_fill > 40 || $urandom_range(0, 3) == 0) begin
        send_item(ACT_CLEAR, $urandom, 16'($urandom));
      end
      if ($urandom_range(0, 99) < 85) begin
        m = $urandom_range(1, 12);
        for (int i = 0; i < m; i++) begin
          k = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 40) : $urandom;
          send_item(ACT_INSERT, k, 16'($urandom));
        end
        if ($urandom_range(0, 9) != 0) send_item(ACT_SORT, $urandom, 16'($urandom));
        m = $urandom_range(3, 8);
        for (int i = 0; i < m; i++) begin
          case ($urandom_range(0, 5))
            0:       k = cur_resv;
            1:       k = $urandom;
            2:       k = $urandom_range(0, 40);
            default: k = loaded_keys[$urandom_range(0, loaded_keys.size() - 1)];
          endcase
          send_item(ACT_LOOKUP, k, 16'($urandom));
        end
      end else begin
        send_item(action_e'($urandom_range(0, 3)), $urandom, 16'($urandom));
      end
    end
  endtask

  // Reset, directed and full-table items, random phases under several register settings, verdict.
  initial begin
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_if.valid  = 1'b0;
    in_if.action = ACT_CLEAR;
    in_if.key    = '0;
    in_if.handle = '0;
    no_stall     = 1'b0;
    cur_resv     = RESERVED_KEY_RST;
    sent_cnt     = 0;
    table_fill   = 0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: empty table, reserved key, unsorted lookup, duplicates and key extremes.
    send_item(ACT_LOOKUP, 32'd7, 16'h0);
    send_item(ACT_LOOKUP, RESERVED_KEY_RST, 16'h0);
    send_item(ACT_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(ACT_INSERT, 32'd5, 16'h0001);
    send_item(ACT_INSERT, 32'd0, 16'h0000);
    send_item(ACT_INSERT, 32'd5, 16'h0002);
    send_item(ACT_LOOKUP, 32'd5, 16'h0);
    send_item(ACT_LOOKUP, RESERVED_KEY_RST, 16'h0);
    send_item(ACT_SORT, 32'd0, 16'h0);
    send_item(ACT_LOOKUP, 32'd0, 16'h0);
    send_item(ACT_LOOKUP, 32'hFFFF_FFFF, 16'h0);
    send_item(ACT_LOOKUP, 32'd5, 16'h0);
    send_item(ACT_LOOKUP, 32'd6, 16'h0);
    send_item(ACT_SORT, 32'd0, 16'h0);
    send_item(ACT_CLEAR, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(ACT_LOOKUP, 32'd5, 16'h0);

    // Full table: ascending keys keep the sort short; one more insert is refused.
    no_stall = 1'b1;
    for (int i = 0; i < DEPTH; i++) send_item(ACT_INSERT, 32'd8 + 4 * i, 16'(i));
    send_item(ACT_INSERT, 32'd3, 16'hABCD);
    send_item(ACT_SORT, 32'd0, 16'h0);
    send_item(ACT_LOOKUP, 32'd8, 16'h0);
    send_item(ACT_LOOKUP, 32'd8 + 4 * (DEPTH - 1), 16'h0);
    send_item(ACT_LOOKUP, 32'd9, 16'h0);
    send_item(ACT_LOOKUP, 32'd8 + 4 * 511, 16'h0);
    send_item(ACT_CLEAR, 32'd0, 16'h0);
    no_stall = 1'b0;

    random_phase(RAND_ITEMS / 5);
    write_resv(32'd0);
    random_phase(RAND_ITEMS / 5);
    write_resv(32'hFFFF_FFFF);
    random_phase(RAND_ITEMS / 5);
    write_resv(32'd17);
    random_phase(RAND_ITEMS / 5);
    write_resv($urandom);
    random_phase(RAND_ITEMS / 5);

    while (pending != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("[sorted_key_table_lookup] OK");
    end else begin
      $display("[sorted_key_table_lookup] ERROR");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #40_000_000;
    $display("[sorted_key_table_lookup] ERROR");
    $finish;
  end

endmodule
